// File: rtl/bba_pkg.sv
// Shared types and constants of the buddy block allocator.
package bba_pkg;

    localparam int LENW = 26;
    localparam int LVW = 5;
    localparam int TAGW = 5;
    localparam int MINW = 5;
    localparam int LEVW = 4;
    localparam int CIDXW = 2;
    localparam logic [LENW-1:0] HDR_BYTES = 26'd16;
    localparam logic [LVW-1:0] MIN_LOG2_LO = 5'd5;
    localparam logic [LVW-1:0] MIN_LOG2_HI = 5'd16;
    localparam logic [LVW-1:0] ADDR_LOG2 = 5'd26;
    localparam logic [MINW-1:0] MIN_RESET = 5'd7;
    localparam logic [LEVW-1:0] LEV_RESET = 4'd10;

    typedef enum logic [CIDXW-1:0] {
        CFG_MIN_BLOCK = 2'd0,
        CFG_TOTAL_LEVELS = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_BAD_FREE = 2'd3
    } status_t;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_PICK,
        S_DESC,
        S_SPLIT,
        S_TAG_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_FREE_WR,
        S_UP_RD,
        S_UP_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic kind;
        logic [LENW-1:0] request_length;
        logic [LENW-1:0] payload_offset;
    } in_t;

    typedef struct packed {
        status_t status;
        logic [LENW-1:0] result_offset;
    } out_t;

    typedef struct packed {
        logic [MINW-1:0] min_block_log2;
        logic [LEVW-1:0] total_levels;
        logic reinit;
    } cfg_t;

endpackage

// File: rtl/bba_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/bba_core.sv
// Allocator sequencer: tree search, split, merge and summary update over the node RAM.
module bba_core #(
    parameter int CAP = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bba_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  bba_pkg::in_t      s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bba_pkg::out_t     m_data,
    output logic              map_we,
    output logic [CAP:0]      map_waddr,
    output logic [CAP:0]      map_wdata,
    output logic [CAP:0]      map_raddr,
    input  logic [CAP:0]      map_rdata,
    output logic              tag_we,
    output logic [CAP-1:0]    tag_waddr,
    output logic [bba_pkg::TAGW-1:0] tag_wdata,
    output logic [CAP-1:0]    tag_raddr,
    input  logic [bba_pkg::TAGW-1:0] tag_rdata
);

    localparam int NAW = CAP + 1;
    localparam int MW = CAP + 1;
    localparam int TAW = CAP;
    localparam int LENW = bba_pkg::LENW;
    localparam int LVW = bba_pkg::LVW;
    localparam logic [NAW-1:0] LAST_NODE = NAW'((2 ** (CAP + 1)) - 2);
    localparam logic [LVW-1:0] CAP_L = LVW'(CAP);

    bba_pkg::state_t state_reg, state_next;
    bba_pkg::in_t item_reg, item_next;
    bba_pkg::out_t res_reg, res_next;
    bba_pkg::out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [NAW-1:0] idx_reg, idx_next;
    logic [LVW-1:0] dep_reg, dep_next;
    logic [LVW-1:0] d_reg, d_next;
    logic [LVW-1:0] j_reg, j_next;
    logic [MW-1:0] cmask_reg, cmask_next;
    logic [TAW-1:0] leaf_reg, leaf_next;

    // Effective configuration after clamping.
    logic [LVW-1:0] eff_m, lev_cap, lev_in, eff_l;
    always_comb begin
        if (cfg.min_block_log2 < bba_pkg::MIN_LOG2_LO) begin
            eff_m = bba_pkg::MIN_LOG2_LO;
        end else if (cfg.min_block_log2 > bba_pkg::MIN_LOG2_HI) begin
            eff_m = bba_pkg::MIN_LOG2_HI;
        end else begin
            eff_m = cfg.min_block_log2;
        end
        lev_cap = (CAP_L < bba_pkg::ADDR_LOG2 - eff_m) ? CAP_L : bba_pkg::ADDR_LOG2 - eff_m;
        lev_in = LVW'(cfg.total_levels);
        eff_l = (lev_in > lev_cap) ? lev_cap : lev_in;
    end

    // Allocation sizing: total bytes, size class and target depth.
    logic [LENW:0] need, need_m1;
    logic [LVW-1:0] need_log2, size_log2, alloc_d;
    logic too_large;
    always_comb begin
        need = {1'b0, item_reg.request_length} + {1'b0, bba_pkg::HDR_BYTES};
        need_m1 = need - (LENW+1)'(1);
        need_log2 = '0;
        for (int i = 0; i <= LENW; i++) begin
            if (need_m1[i]) begin
                need_log2 = LVW'(i + 1);
            end
        end
        size_log2 = (need_log2 > eff_m) ? need_log2 : eff_m;
        too_large = need > ((LENW+1)'(1) << (eff_m + eff_l));
        alloc_d = eff_l + eff_m - size_log2;
    end

    // Free checks on the offset.
    logic [LENW-1:0] blk_start, leaf_full;
    logic bad_offset;
    always_comb begin
        blk_start = item_reg.payload_offset - bba_pkg::HDR_BYTES;
        leaf_full = blk_start >> eff_m;
        bad_offset = (item_reg.payload_offset < bba_pkg::HDR_BYTES)
                  || ((blk_start & ((LENW'(1) << eff_m) - LENW'(1))) != '0)
                  || (leaf_full >= (LENW'(1) << eff_l));
    end

    // Search helpers on the root summary.
    logic [MW-1:0] low_mask, avail;
    logic [LVW-1:0] pick_j;
    always_comb begin
        low_mask = (MW'(2) << d_reg) - MW'(1);
        avail = map_rdata & low_mask;
        pick_j = '0;
        for (int i = 0; i < MW; i++) begin
            if (avail[i]) begin
                pick_j = LVW'(i);
            end
        end
    end

    // Tree address helpers.
    logic [NAW-1:0] left_idx, sib_idx, parent_idx, child_idx, blk_k;
    logic [LVW-1:0] tag_d;
    logic [NAW-1:0] free_idx;
    logic q_bit_j, q_bit_dep;
    always_comb begin
        left_idx = {idx_reg[NAW-2:0], 1'b1};
        sib_idx = idx_reg[0] ? idx_reg + NAW'(1) : idx_reg - NAW'(1);
        parent_idx = (idx_reg - NAW'(1)) >> 1;
        q_bit_j = |(map_rdata & (MW'(1) << j_reg));
        q_bit_dep = |(map_rdata & (MW'(1) << dep_reg));
        child_idx = q_bit_j ? left_idx : left_idx + NAW'(1);
        blk_k = idx_reg + NAW'(1) - (NAW'(1) << dep_reg);
        tag_d = tag_rdata - bba_pkg::TAGW'(1);
        free_idx = (NAW'(1) << tag_d) - NAW'(1) + NAW'(leaf_reg >> (eff_l - tag_d));
    end

    // No transaction is taken in the cycle that a levels write restarts the sweep.
    assign s_ready = (state_reg == bba_pkg::S_IDLE) && !cfg.reinit;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    // State and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bba_pkg::S_CLEAR;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg <= res_next;
        out_reg <= out_next;
        dep_reg <= dep_next;
        d_reg <= d_next;
        j_reg <= j_next;
        cmask_reg <= cmask_next;
        leaf_reg <= leaf_next;
    end

    // Next state, memory accesses and result.
    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        idx_next = idx_reg;
        dep_next = dep_reg;
        d_next = d_reg;
        j_next = j_reg;
        cmask_next = cmask_reg;
        leaf_next = leaf_reg;
        map_we = 1'b0;
        map_waddr = idx_reg;
        map_wdata = '0;
        map_raddr = '0;
        tag_we = 1'b0;
        tag_waddr = leaf_reg;
        tag_wdata = '0;
        tag_raddr = leaf_reg;

        unique case (state_reg)
            bba_pkg::S_CLEAR: begin
                map_we = 1'b1;
                map_wdata = (idx_reg == '0) ? MW'(1) : '0;
                tag_we = 1'b1;
                tag_waddr = idx_reg[TAW-1:0];
                idx_next = idx_reg + NAW'(1);
                if (idx_reg == LAST_NODE) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    state_next = bba_pkg::S_PREP;
                end
            end
            bba_pkg::S_PREP: begin
                res_next.result_offset = '0;
                res_next.status = bba_pkg::STAT_OK;
                if (item_reg.kind == bba_pkg::KIND_ALLOC) begin
                    if (too_large) begin
                        res_next.status = bba_pkg::STAT_TOO_LARGE;
                        state_next = bba_pkg::S_DONE;
                    end else begin
                        d_next = alloc_d;
                        map_raddr = '0;
                        state_next = bba_pkg::S_PICK;
                    end
                end else begin
                    if (bad_offset) begin
                        res_next.status = bba_pkg::STAT_BAD_FREE;
                        state_next = bba_pkg::S_DONE;
                    end else begin
                        leaf_next = leaf_full[TAW-1:0];
                        tag_raddr = leaf_full[TAW-1:0];
                        state_next = bba_pkg::S_TAG_CHK;
                    end
                end
            end
            bba_pkg::S_PICK: begin
                idx_next = '0;
                dep_next = '0;
                j_next = pick_j;
                if (avail == '0) begin
                    res_next.status = bba_pkg::STAT_NO_SPACE;
                    state_next = bba_pkg::S_DONE;
                end else if (pick_j == '0) begin
                    state_next = bba_pkg::S_SPLIT;
                end else begin
                    map_raddr = NAW'(1);
                    state_next = bba_pkg::S_DESC;
                end
            end
            bba_pkg::S_DESC: begin
                // Follow the leftmost branch that holds a free block of depth j.
                idx_next = child_idx;
                dep_next = dep_reg + LVW'(1);
                map_raddr = {child_idx[NAW-2:0], 1'b1};
                if (dep_reg + LVW'(1) == j_reg) begin
                    state_next = bba_pkg::S_SPLIT;
                end
            end
            bba_pkg::S_SPLIT: begin
                if (dep_reg < d_reg) begin
                    // Keep the lower half, free the upper half.
                    map_we = 1'b1;
                    map_waddr = left_idx + NAW'(1);
                    map_wdata = MW'(1) << (dep_reg + LVW'(1));
                    idx_next = left_idx;
                    dep_next = dep_reg + LVW'(1);
                end else begin
                    map_we = 1'b1;
                    map_wdata = '0;
                    tag_we = 1'b1;
                    tag_waddr = TAW'(blk_k << (eff_l - d_reg));
                    tag_wdata = bba_pkg::TAGW'(d_reg + LVW'(1));
                    res_next.result_offset = (LENW'(blk_k) << (eff_m + eff_l - d_reg))
                                           + bba_pkg::HDR_BYTES;
                    cmask_next = '0;
                    state_next = (dep_reg == '0) ? bba_pkg::S_DONE : bba_pkg::S_UP_RD;
                end
            end
            bba_pkg::S_TAG_CHK: begin
                if (tag_rdata == '0 || tag_d > eff_l) begin
                    res_next.status = bba_pkg::STAT_BAD_FREE;
                    state_next = bba_pkg::S_DONE;
                end else begin
                    tag_we = 1'b1;
                    idx_next = free_idx;
                    dep_next = tag_d;
                    state_next = (tag_d == '0) ? bba_pkg::S_FREE_WR : bba_pkg::S_MERGE_RD;
                end
            end
            bba_pkg::S_MERGE_RD: begin
                map_raddr = sib_idx;
                state_next = bba_pkg::S_MERGE_CHK;
            end
            bba_pkg::S_MERGE_CHK: begin
                // A whole free buddy is absorbed into the parent.
                if (q_bit_dep) begin
                    map_we = 1'b1;
                    map_waddr = sib_idx;
                    map_wdata = '0;
                    idx_next = parent_idx;
                    dep_next = dep_reg - LVW'(1);
                    state_next = (dep_reg == LVW'(1)) ? bba_pkg::S_FREE_WR
                                                     : bba_pkg::S_MERGE_RD;
                end else begin
                    state_next = bba_pkg::S_FREE_WR;
                end
            end
            bba_pkg::S_FREE_WR: begin
                map_we = 1'b1;
                map_wdata = MW'(1) << dep_reg;
                cmask_next = MW'(1) << dep_reg;
                state_next = (dep_reg == '0) ? bba_pkg::S_DONE : bba_pkg::S_UP_RD;
            end
            bba_pkg::S_UP_RD: begin
                map_raddr = sib_idx;
                state_next = bba_pkg::S_UP_WR;
            end
            bba_pkg::S_UP_WR: begin
                // Parent summary is the union of both children.
                map_we = 1'b1;
                map_waddr = parent_idx;
                map_wdata = cmask_reg | map_rdata;
                cmask_next = cmask_reg | map_rdata;
                idx_next = parent_idx;
                dep_next = dep_reg - LVW'(1);
                state_next = (dep_reg == LVW'(1)) ? bba_pkg::S_DONE : bba_pkg::S_UP_RD;
            end
            bba_pkg::S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::S_CLEAR;
            end
        endcase

        // A levels write restarts the clearing sweep.
        if (cfg.reinit) begin
            state_next = bba_pkg::S_CLEAR;
            idx_next = '0;
        end
    end

endmodule

// File: rtl/buddy_block_allocator_unit.sv
// Top level of the buddy block allocator: configuration registers, node and tag RAMs, sequencer.
//
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------------------
//  input   | s_valid, s_ready, s_data       | kind, request_length, payload_offset
//  result  | m_valid, m_ready, m_data       | status, result_offset
//  config  | cfg_we, cfg_index, cfg_wdata   | min_block_log2, total_levels
//
// One item is worked at a time. An allocate is sized, searched from the root summary,
// split down to its depth and then summarised up to the root; a too-large request or a
// full memory ends early. A free checks its offset and depth tag, merges with free
// buddies and updates the summaries above; an invalid free ends early.
// After reset and after each total_levels write a clearing pass over every node runs,
// with s_ready low. A result waits in the output register while the
// next transaction is taken; the sequencer stalls only when a second result is due.
module buddy_block_allocator_unit #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bba_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bba_pkg::out_t                 m_data,
    input  logic                          cfg_we,
    input  logic [bba_pkg::CIDXW-1:0]     cfg_index,
    input  logic [bba_pkg::MINW-1:0]      cfg_wdata
);

    localparam int CAP = $clog2(MAX_BLOCKS + 1) - 1;
    localparam int NODES = (2 ** (CAP + 1)) - 1;
    localparam int LEAVES = 2 ** CAP;

    logic [bba_pkg::MINW-1:0] min_reg;
    logic [bba_pkg::LEVW-1:0] lev_reg;
    logic reinit_reg;
    bba_pkg::cfg_t cfg;

    logic map_we;
    logic [CAP:0] map_waddr, map_wdata, map_raddr, map_rdata;
    logic tag_we;
    logic [CAP-1:0] tag_waddr, tag_raddr;
    logic [bba_pkg::TAGW-1:0] tag_wdata, tag_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= bba_pkg::MIN_RESET;
            lev_reg <= bba_pkg::LEV_RESET;
            reinit_reg <= 1'b0;
        end else begin
            reinit_reg <= 1'b0;
            if (cfg_we && cfg_index == bba_pkg::CFG_MIN_BLOCK) begin
                min_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == bba_pkg::CFG_TOTAL_LEVELS) begin
                lev_reg <= cfg_wdata[bba_pkg::LEVW-1:0];
                reinit_reg <= 1'b1;
            end
        end
    end

    assign cfg.min_block_log2 = min_reg;
    assign cfg.total_levels = lev_reg;
    assign cfg.reinit = reinit_reg;

    // Free-summary tree, one mask of free depths per node.
    bba_ram #(
        .WIDTH(CAP + 1),
        .DEPTH(NODES)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Depth tag of each allocated block, by start position.
    bba_ram #(
        .WIDTH(bba_pkg::TAGW),
        .DEPTH(LEAVES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    bba_core #(
        .CAP(CAP)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .map_we    (map_we),
        .map_waddr (map_waddr),
        .map_wdata (map_wdata),
        .map_raddr (map_raddr),
        .map_rdata (map_rdata),
        .tag_we    (tag_we),
        .tag_waddr (tag_waddr),
        .tag_wdata (tag_wdata),
        .tag_raddr (tag_raddr),
        .tag_rdata (tag_rdata)
    );

endmodule

// File: tb/buddy_block_allocator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the buddy block allocator: directed table, random traffic, predictor.
module buddy_block_allocator_unit_test;

    localparam int NUM_BLOCKS = 1024;
    localparam int NODE_COUNT = 2 * NUM_BLOCKS - 1;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int CLEAR_CYCLES = 2 * NUM_BLOCKS + 16;
    localparam int LENW = bba_pkg::LENW;
    localparam int MINW = bba_pkg::MINW;
    localparam int LEVW = bba_pkg::LEVW;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    bba_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bba_pkg::out_t m_data;
    logic cfg_we = 1'b0;
    logic [bba_pkg::CIDXW-1:0] cfg_index = '0;
    logic [MINW-1:0] cfg_wdata = '0;

    buddy_block_allocator_unit #(.MAX_BLOCKS(NUM_BLOCKS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the allocator state.
    bit node_free [NODE_COUNT];
    bit [4:0] depth_tag [NUM_BLOCKS];
    bit [4:0] shadow_min;
    bit [3:0] shadow_levels;

    bba_pkg::out_t pending_results[$];
    logic [LENW-1:0] live_offsets[$];
    int error_count = 0;
    int idle_cycles = 0;
    int results_seen = 0;
    int items_sent = 0;
    bit long_hold = 0;

    function automatic int min_log2();
        if (shadow_min < 5) return 5;
        if (shadow_min > 16) return 16;
        return shadow_min;
    endfunction

    function automatic int level_count();
        int cap;
        cap = 10;
        if (cap > 26 - min_log2()) cap = 26 - min_log2();
        return (shadow_levels > cap) ? cap : shadow_levels;
    endfunction

    function automatic void clear_store();
        foreach (node_free[i]) node_free[i] = 0;
        foreach (depth_tag[i]) depth_tag[i] = 0;
        node_free[0] = 1;
    endfunction

    // Allocation: smallest fitting size, lowest-addressed block at the deepest free depth, split downward.
    function automatic bba_pkg::out_t predict_alloc(logic [LENW-1:0] len);
        bba_pkg::out_t r;
        longint need, idx, k;
        int m, lv_count, d, lv;
        m = min_log2();
        lv_count = level_count();
        need = longint'(len) + 16;
        r.status = bba_pkg::STAT_OK;
        r.result_offset = '0;
        if (need > (64'd1 << (m + lv_count))) begin
            r.status = bba_pkg::STAT_TOO_LARGE;
            return r;
        end
        d = lv_count;
        while (d > 0 && (64'd1 << (m + lv_count - d)) < need) d--;
        for (int j = d; j >= 0; j--) begin
            for (k = 0; k < (64'd1 << j); k++) begin
                idx = (64'd1 << j) - 1 + k;
                if (idx < NODE_COUNT && node_free[idx]) begin
                    node_free[idx] = 0;
                    lv = j;
                    while (lv < d) begin
                        idx = 2 * idx + 1;
                        if (idx + 1 < NODE_COUNT) node_free[idx + 1] = 1;
                        k = k * 2;
                        lv++;
                    end
                    if ((k << (lv_count - d)) < NUM_BLOCKS)
                        depth_tag[k << (lv_count - d)] = 5'(d + 1);
                    r.result_offset = LENW'((k << (m + lv_count - d)) + 16);
                    return r;
                end
            end
        end
        r.status = bba_pkg::STAT_NO_SPACE;
        return r;
    endfunction

    // Free: validate the offset, then merge with free buddies upward.
    function automatic bba_pkg::out_t predict_free(logic [LENW-1:0] off);
        bba_pkg::out_t r;
        longint start, leaf, idx, buddy;
        int m, lv_count, d;
        m = min_log2();
        lv_count = level_count();
        r.status = bba_pkg::STAT_BAD_FREE;
        r.result_offset = '0;
        if (off < 16) return r;
        start = longint'(off) - 16;
        if (start & ((64'd1 << m) - 1)) return r;
        leaf = start >> m;
        if (leaf >= (64'd1 << lv_count) || leaf >= NUM_BLOCKS) return r;
        if (depth_tag[leaf] == 0 || depth_tag[leaf] - 1 > lv_count) return r;
        d = depth_tag[leaf] - 1;
        idx = (64'd1 << d) - 1 + (leaf >> (lv_count - d));
        if (idx >= NODE_COUNT) return r;
        depth_tag[leaf] = 0;
        while (d > 0) begin
            buddy = (idx & 1) ? idx + 1 : idx - 1;
            if (buddy >= NODE_COUNT || !node_free[buddy]) break;
            node_free[buddy] = 0;
            idx = (idx - 1) / 2;
            d--;
        end
        node_free[idx] = 1;
        r.status = bba_pkg::STAT_OK;
        return r;
    endfunction

    // Send one transaction and queue its expected result; valid stays high for the next one.
    task automatic send_item(bba_pkg::in_t item, bit typed, bba_pkg::out_t typed_result);
        bba_pkg::out_t r;
        if (item.kind == bba_pkg::KIND_ALLOC) r = predict_alloc(item.request_length);
        else r = predict_free(item.payload_offset);
        if (typed && r != typed_result)
            $display("%0t: directed table row disagrees with predictor: %h vs %h",
                     $time, typed_result, r);
        if (typed) r = typed_result;
        if (item.kind == bba_pkg::KIND_ALLOC && r.status == bba_pkg::STAT_OK)
            live_offsets.push_back(r.result_offset);
        pending_results.push_back(r);
        s_data <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(bba_pkg::cfg_index_t idx, logic [MINW-1:0] value);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == bba_pkg::CFG_MIN_BLOCK) shadow_min = value;
        else begin
            shadow_levels = value[LEVW-1:0];
            clear_store();
            live_offsets.delete();
        end
    endtask

    function automatic bba_pkg::in_t make_alloc(logic [LENW-1:0] len);
        bba_pkg::in_t it;
        it.kind = bba_pkg::KIND_ALLOC;
        it.request_length = len;
        it.payload_offset = LENW'($urandom());
        return it;
    endfunction

    function automatic bba_pkg::in_t make_free(logic [LENW-1:0] off);
        bba_pkg::in_t it;
        it.kind = bba_pkg::KIND_FREE;
        it.request_length = LENW'($urandom());
        it.payload_offset = off;
        return it;
    endfunction

    // Random item mix: mostly fitting allocations and frees of live blocks.
    function automatic bba_pkg::in_t random_item();
        int pick, span, q;
        pick = $urandom_range(0, 99);
        span = min_log2() + level_count();
        if (pick < 45) begin
            return make_alloc(LENW'($urandom_range(0, 1 << $urandom_range(0, span))));
        end else if (pick < 85 && live_offsets.size() > 0) begin
            q = $urandom_range(0, live_offsets.size() - 1);
            return make_free(live_offsets[q]);
        end else if (pick < 92) begin
            return make_alloc(LENW'($urandom()));
        end
        return make_free(LENW'((pick & 1) ? $urandom() : $urandom_range(0, 1 << span)));
    endfunction

    task automatic random_phase(int count);
        int gap;
        int q;
        bba_pkg::in_t it;
        for (int n = 0; n < count; n++) begin
            it = random_item();
            if (it.kind == bba_pkg::KIND_FREE)
                for (q = 0; q < live_offsets.size(); q++)
                    if (live_offsets[q] == it.payload_offset) begin
                        live_offsets.delete(q);
                        break;
                    end
            send_item(it, 0, '0);
            if ($urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Receiver: stall pattern plus one long hold-off.
    always @(negedge aclk) begin
        if (long_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Result checking and idle watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                error_count++;
            end else begin
                if (m_data.status !== pending_results[0].status ||
                    m_data.result_offset !== pending_results[0].result_offset) begin
                    $display("%0t: mismatch expected %h actual %h",
                             $time, pending_results[0], m_data);
                    error_count++;
                end
                void'(pending_results.pop_front());
            end
            results_seen++;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("buddy_block_allocator_unit test failed");
            $finish;
        end
    end

    typedef struct {
        bba_pkg::in_t item;
        bit typed;
        bba_pkg::out_t result;
    } table_row_t;

    table_row_t dir_table[$];
    bba_pkg::out_t ok_res;

    initial begin
        shadow_min = bba_pkg::MIN_RESET;
        shadow_levels = bba_pkg::LEV_RESET;
        clear_store();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (CLEAR_CYCLES) @(negedge aclk);

        // Directed rows at reset configuration: 128-byte min block, 1024 blocks.
        ok_res.status = bba_pkg::STAT_OK;
        ok_res.result_offset = 26'd16;
        dir_table.push_back('{make_alloc(26'd0), 1, ok_res});
        dir_table.push_back('{make_free(26'd16), 1, '{bba_pkg::STAT_OK, 26'd0}});
        dir_table.push_back('{make_free(26'd16), 1, '{bba_pkg::STAT_BAD_FREE, 26'd0}});
        dir_table.push_back('{make_free(26'd0), 1, '{bba_pkg::STAT_BAD_FREE, 26'd0}});
        dir_table.push_back('{make_free(26'd17), 1, '{bba_pkg::STAT_BAD_FREE, 26'd0}});
        dir_table.push_back('{make_free(26'h3FFFFFF), 1, '{bba_pkg::STAT_BAD_FREE, 26'd0}});
        dir_table.push_back('{make_alloc(26'h3FFFFFF), 1, '{bba_pkg::STAT_TOO_LARGE, 26'd0}});
        dir_table.push_back('{make_alloc(26'd131057), 1, '{bba_pkg::STAT_TOO_LARGE, 26'd0}});
        dir_table.push_back('{make_alloc(26'd131056), 1, '{bba_pkg::STAT_OK, 26'd16}});
        dir_table.push_back('{make_alloc(26'd0), 1, '{bba_pkg::STAT_NO_SPACE, 26'd0}});
        dir_table.push_back('{make_free(26'd16), 1, '{bba_pkg::STAT_OK, 26'd0}});
        dir_table.push_back('{make_alloc(26'd100), 0, '0});
        dir_table.push_back('{make_alloc(26'd113), 0, '0});
        dir_table.push_back('{make_alloc(26'd5000), 0, '0});
        dir_table.push_back('{make_free(26'd144), 0, '0});
        dir_table.push_back('{make_free(26'd16), 0, '0});
        dir_table.push_back('{make_free(26'd400), 0, '0});
        foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].result);
        // Blocks still held after the table: the 256-byte and the 8 KiB allocations.
        live_offsets.delete();
        live_offsets.push_back(26'd272);
        live_offsets.push_back(26'd8208);

        random_phase(150);

        // Long receiver hold-off while the sender keeps offering items.
        fork
            begin
                long_hold = 1;
                repeat (300) @(negedge aclk);
                long_hold = 0;
            end
            random_phase(40);
        join

        // Configuration sweep including extremes and out-of-range values.
        write_reg(bba_pkg::CFG_TOTAL_LEVELS, 5'd0);
        random_phase(20);
        write_reg(bba_pkg::CFG_MIN_BLOCK, 5'd5);
        write_reg(bba_pkg::CFG_TOTAL_LEVELS, 5'd15);
        random_phase(120);
        write_reg(bba_pkg::CFG_MIN_BLOCK, 5'd31);
        random_phase(60);
        write_reg(bba_pkg::CFG_TOTAL_LEVELS, 5'd3);
        random_phase(60);
        write_reg(bba_pkg::CFG_MIN_BLOCK, 5'd0);
        random_phase(40);
        write_reg(bba_pkg::CFG_MIN_BLOCK, 5'd16);
        write_reg(bba_pkg::CFG_TOTAL_LEVELS, 5'd10);
        random_phase(100);
        write_reg(bba_pkg::CFG_MIN_BLOCK, 5'd10);
        write_reg(bba_pkg::CFG_TOTAL_LEVELS, 5'd1);
        random_phase(90);

        wait_drain();
        $display("Run covered %0d transactions and %0d results over eight configurations.",
                 items_sent, results_seen);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("buddy_block_allocator_unit test passed");
        end else begin
            $display("buddy_block_allocator_unit test failed");
        end
        $finish;
    end
endmodule
